// ===== design/mwpo_pkg.sv =====
// Package for the multi-waveform phase oscillator.
// Holds widths, output codes and the quarter-wave sine table built at elaboration.
// No dependencies.
`default_nettype none

package mwpo_pkg;

  localparam int PHASE_W      = 32;
  localparam int FREQ_W       = 32;
  localparam int STEP_W       = 32;
  localparam int OFFSET_W     = 32;
  localparam int DUTY_W       = 17;
  localparam int SAMPLE_W     = 16;
  localparam int SINE_LOG2    = 8;
  localparam int SINE_ENTRIES = 1 << SINE_LOG2;
  localparam int SINE_W       = 15;

  localparam int IN_DATA_W    = ((STEP_W + OFFSET_W + DUTY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = 5 * SAMPLE_W;

  localparam logic signed [SAMPLE_W-1:0] PEAK_POS = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = -16'sd32767;
  localparam logic [SINE_W-1:0]          PEAK_MAG = 15'd32767;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // series divisors k*(k+1) for k = 12, 10, 8, 6, 4, 2
  localparam logic [63:0] SERIES_DIV_12 = 64'd156;
  localparam logic [63:0] SERIES_DIV_10 = 64'd110;
  localparam logic [63:0] SERIES_DIV_8  = 64'd72;
  localparam logic [63:0] SERIES_DIV_6  = 64'd42;
  localparam logic [63:0] SERIES_DIV_4  = 64'd20;
  localparam logic [63:0] SERIES_DIV_2  = 64'd6;

  typedef logic [SINE_W-1:0] sine_tab_t [SINE_ENTRIES];

  // sin(x) on [0, pi/2], Q30 in and out, nested series
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / SERIES_DIV_12);
    t  = Q30_ONE - (((x2 * t) >> 30) / SERIES_DIV_10);
    t  = Q30_ONE - (((x2 * t) >> 30) / SERIES_DIV_8);
    t  = Q30_ONE - (((x2 * t) >> 30) / SERIES_DIV_6);
    t  = Q30_ONE - (((x2 * t) >> 30) / SERIES_DIV_4);
    t  = Q30_ONE - (((x2 * t) >> 30) / SERIES_DIV_2);
    return (x * t) >> 30;
  endfunction

  // Entries 0..SINE_ENTRIES-1; the peak entry at SINE_ENTRIES is handled in logic
  function automatic sine_tab_t build_sine_table();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] v;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      x = (HALF_PI_Q30 * 64'(i)) / SINE_ENTRIES;
      v = (sine_q30(x) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      tab[i] = v[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

// ===== design/multi_waveform_phase_oscillator_top.sv =====
// Multi-waveform phase oscillator, top level.
// Uses mwpo_pkg for widths, constants and the quarter-wave sine table.
// Four register stages: input, increment, phase, result.
`default_nettype none

// One item enters per clock when the result side keeps up. Stage one multiplies
// frequency by time step (32x32), stage two adds increment and offset change into
// the phase accumulator, and stage three reads the quarter-wave table and forms
// the five waveforms into the result register. Each stage moves on when the one
// after it is empty or draining, so stalls only back up the stages behind the
// waiting result. frequency_hz is written through cfg_wr_en / cfg_wr_data by the
// user only while the block is idle; the block itself does not enforce this.
module multi_waveform_phase_oscillator_top
  import mwpo_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_wr_en,
  input  wire [FREQ_W-1:0]       cfg_wr_data,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // [31:0] time_step, [63:32] phase_offset, [80:64] pwm_duty, rest zero
  input  wire [IN_DATA_W-1:0]    in_tdata,
  // [0] restart
  input  wire                    in_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // [15:0] sine_out, [31:16] square_out, [47:32] saw_out,
  // [63:48] triangle_out, [79:64] pwm_out
  output logic [OUT_DATA_W-1:0]  out_tdata
);

  localparam int SINE_SHIFT = PHASE_W - 2 - SINE_LOG2;

  // configuration
  logic [FREQ_W-1:0]   freq_r;

  // stage 1: input register
  logic                v1_r;
  logic [STEP_W-1:0]   step1_r;
  logic [OFFSET_W-1:0] off1_r;
  logic [DUTY_W-1:0]   duty1_r;
  logic                rst1_r;

  // stage 2: increment and offset change
  logic                v2_r;
  logic [PHASE_W-1:0]  inc2_r;
  logic [PHASE_W-1:0]  delta2_r;
  logic [DUTY_W-1:0]   duty2_r;
  logic                rst2_r;
  logic [OFFSET_W-1:0] prev_off_r;

  // stage 3: phase accumulator doubles as the stage register
  logic                v3_r;
  logic [PHASE_W-1:0]  acc_r;
  logic [DUTY_W-1:0]   duty3_r;

  // result register
  logic                vo_r;
  logic [OUT_DATA_W-1:0] out_r;

  logic rdy_o, rdy3, rdy2, rdy1;
  logic [FREQ_W+STEP_W-1:0] prod;
  logic [PHASE_W-1:0]       acc_nxt;

  assign rdy_o     = !vo_r || out_tready;
  assign rdy3      = !v3_r || rdy_o;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign out_tvalid = vo_r;
  assign out_tdata  = out_r;

  assign prod    = 64'(step1_r) * 64'(freq_r);
  assign acc_nxt = rst2_r ? '0 : acc_r + inc2_r + delta2_r;

  // ---------------- waveform logic on the accumulated phase ----------------
  logic [1:0]                quad;
  logic [SINE_LOG2-1:0]      idx;
  logic [SINE_LOG2-1:0]      idx_m;
  logic [SINE_W-1:0]         sine_mag;
  logic signed [SAMPLE_W-1:0] sine_w, square_w, saw_w, tri_w, pwm_w;
  logic [16:0]               tri_k;
  logic signed [18:0]        tri_raw;
  logic                      pwm_hi;

  always_comb begin
    quad  = acc_r[PHASE_W-1 -: 2];
    idx   = acc_r[SINE_SHIFT +: SINE_LOG2];
    idx_m = SINE_LOG2'(0) - idx;
    // mirrored index of zero lands on the peak entry beyond the table
    if (quad[0]) begin
      sine_mag = (idx == '0) ? PEAK_MAG : SINE_TABLE[idx_m];
    end else begin
      sine_mag = SINE_TABLE[idx];
    end
    sine_w = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

    square_w = acc_r[PHASE_W-1] ? PEAK_NEG : PEAK_POS;

    // falling ramp; only the top end clamps
    if (acc_r[PHASE_W-1 -: 16] == '0) begin
      saw_w = PEAK_POS;
    end else begin
      saw_w = $signed(16'h8000 - acc_r[PHASE_W-1 -: 16]);
    end

    tri_k = acc_r[PHASE_W-1 -: 17];
    if (quad == 2'b00) begin
      tri_raw = $signed({2'b00, tri_k});
    end else if (quad == 2'b11) begin
      tri_raw = $signed({2'b00, tri_k}) - 19'sd131072;
    end else begin
      tri_raw = 19'sd65536 - $signed({2'b00, tri_k});
    end
    if (tri_raw > 19'sd32767) begin
      tri_w = PEAK_POS;
    end else if (tri_raw < -19'sd32767) begin
      tri_w = PEAK_NEG;
    end else begin
      tri_w = tri_raw[SAMPLE_W-1:0];
    end

    // duty of one or more always high
    pwm_hi = duty3_r[DUTY_W-1] || (acc_r[PHASE_W-1 -: 16] < duty3_r[DUTY_W-2:0]);
    pwm_w  = pwm_hi ? PEAK_POS : PEAK_NEG;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r     <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      vo_r       <= 1'b0;
      prev_off_r <= '0;
      acc_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        freq_r <= cfg_wr_data;
      end
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_o) begin
        vo_r <= v3_r;
      end
      // offset reference advances with each transaction, restart included
      if (rdy2 && v1_r) begin
        prev_off_r <= off1_r;
      end
      if (rdy3 && v2_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      step1_r <= in_tdata[STEP_W-1:0];
      off1_r  <= in_tdata[STEP_W +: OFFSET_W];
      duty1_r <= in_tdata[STEP_W+OFFSET_W +: DUTY_W];
      rst1_r  <= in_tuser;
    end
    if (rdy2 && v1_r) begin
      inc2_r   <= prod[47 -: PHASE_W];
      delta2_r <= off1_r - prev_off_r;
      duty2_r  <= duty1_r;
      rst2_r   <= rst1_r;
    end
    if (rdy3 && v2_r) begin
      duty3_r <= duty2_r;
    end
    if (rdy_o && v3_r) begin
      out_r <= {pwm_w, tri_w, saw_w, square_w, sine_w};
    end
  end

  // ---------------- assertions ----------------
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy3 && v2_r && rst2_r) |=> (acc_r == '0))
    else $error("restart did not clear phase");

  a_square_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_o && v3_r) |=> (out_r[31:16] == ($past(acc_r[PHASE_W-1]) ? PEAK_NEG : PEAK_POS)))
    else $error("square output does not match phase half");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(rdy3 && v2_r) |=> $stable(acc_r))
    else $error("phase changed without a transaction");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(off1_r)))
    else $error("stalled input stage lost its item");

endmodule

`default_nettype wire

// ===== tb/sv/mwpo_waveform_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the multi-waveform phase oscillator: follows frequency writes and
// tick transactions, predicts the five waveform samples and compares each result.
// Depends on mwpo_pkg for widths and peak values.
module mwpo_waveform_checker
  import mwpo_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_wr_en,
  input  wire [FREQ_W-1:0]      cfg_wr_data,
  input  wire                   in_tvalid,
  input  wire                   in_tready,
  input  wire [IN_DATA_W-1:0]   in_tdata,
  input  wire                   in_tuser,
  input  wire                   out_tvalid,
  input  wire                   out_tready,
  input  wire [OUT_DATA_W-1:0]  out_tdata,
  output int                    mismatch_count,
  output int                    results_pending
);

  typedef struct {
    logic signed [SAMPLE_W-1:0] sine;
    logic signed [SAMPLE_W-1:0] square;
    logic signed [SAMPLE_W-1:0] saw;
    logic signed [SAMPLE_W-1:0] triangle;
    logic signed [SAMPLE_W-1:0] pwm;
  } wave_set_t;

  logic [SINE_W-1:0]   quarter_wave [0:SINE_ENTRIES];
  logic [FREQ_W-1:0]   freq_q16;
  logic [PHASE_W-1:0]  phase_acc;
  logic [OFFSET_W-1:0] last_offset;
  wave_set_t           expected_waves [$];
  int                  result_idx;

  // sin(x) on [0, pi/2], Q30 in and out, Horner form of the Taylor series
  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
    logic [63:0] x_sq;
    logic [63:0] term;
    x_sq = (x * x) >> 30;
    term = Q30_ONE;
    for (int k = 12; k >= 2; k -= 2)
      term = Q30_ONE - (((x_sq * term) >> 30) / 64'(k * (k + 1)));
    return (x * term) >> 30;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input int v);
    if (v > 32767) return PEAK_POS;
    if (v < -32767) return PEAK_NEG;
    return v[SAMPLE_W-1:0];
  endfunction

  // Advance the phase for one tick and form the waveforms of the new phase
  function automatic wave_set_t advance_phase(input logic [STEP_W-1:0] step,
                                              input logic [OFFSET_W-1:0] offset,
                                              input logic [DUTY_W-1:0] duty,
                                              input logic restart);
    logic [63:0]          product;
    logic [PHASE_W-1:0]   p;
    logic [SINE_LOG2:0]   idx;
    logic [DUTY_W-1:0]    duty_sat;
    logic signed [SAMPLE_W-1:0] mag;
    int                   k;
    wave_set_t            w;
    if (restart) begin
      phase_acc = '0;
    end else begin
      product   = 64'(freq_q16) * 64'(step);
      phase_acc = phase_acc + product[47:16] + (offset - last_offset);
    end
    last_offset = offset;
    p = phase_acc;

    // mirror the table index in odd quadrants, negate in the second half
    idx = {1'b0, p[29 -: SINE_LOG2]};
    if (p[30]) idx = (SINE_LOG2 + 1)'(SINE_ENTRIES) - idx;
    mag    = $signed({1'b0, quarter_wave[idx]});
    w.sine = p[31] ? -mag : mag;

    w.square = p[31] ? PEAK_NEG : PEAK_POS;
    w.saw    = clamp_sample(32768 - int'(p[31:16]));

    k = int'(p[31:15]);
    if (p < 32'h4000_0000)      w.triangle = clamp_sample(k);
    else if (p < 32'hC000_0000) w.triangle = clamp_sample(65536 - k);
    else                        w.triangle = clamp_sample(k - 131072);

    duty_sat = (duty > 17'd65536) ? 17'd65536 : duty;
    w.pwm    = ({32'd0, p} < (64'(duty_sat) << 16)) ? PEAK_POS : PEAK_NEG;
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_sample(input string field, input logic signed [SAMPLE_W-1:0] got,
                                input logic signed [SAMPLE_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_idx, field, got, want));
  endtask

  initial begin
    logic [63:0] angle;
    logic [63:0] mag;
    mismatch_count  = 0;
    results_pending = 0;
    result_idx      = 0;
    freq_q16        = '0;
    phase_acc       = '0;
    last_offset     = '0;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      angle = (HALF_PI_Q30 * 64'(i)) / SINE_ENTRIES;
      mag   = (quarter_sine_q30(angle) * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      if (mag > 64'd32767) mag = 64'd32767;
      quarter_wave[i] = mag[SINE_W-1:0];
    end
    quarter_wave[SINE_ENTRIES] = PEAK_MAG;
  end

  always @(posedge clk) begin
    wave_set_t got;
    wave_set_t want;
    if (!rst_n) begin
      freq_q16    = '0;
      phase_acc   = '0;
      last_offset = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.sine     = out_tdata[15:0];
        got.square   = out_tdata[31:16];
        got.saw      = out_tdata[47:32];
        got.triangle = out_tdata[63:48];
        got.pwm      = out_tdata[79:64];
        if (expected_waves.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no tick outstanding", result_idx));
        end else begin
          want = expected_waves.pop_front();
          results_pending--;
          compare_sample("sine_out", got.sine, want.sine);
          compare_sample("square_out", got.square, want.square);
          compare_sample("saw_out", got.saw, want.saw);
          compare_sample("triangle_out", got.triangle, want.triangle);
          compare_sample("pwm_out", got.pwm, want.pwm);
        end
        result_idx++;
      end
      if (cfg_wr_en) freq_q16 = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        expected_waves.push_back(advance_phase(in_tdata[31:0], in_tdata[63:32],
                                               in_tdata[80:64], in_tuser));
        results_pending++;
      end
    end
  end

endmodule

// ===== tb/sv/multi_waveform_phase_oscillator_top_test.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the multi-waveform phase oscillator top level.
// Depends on mwpo_pkg, multi_waveform_phase_oscillator_top and mwpo_waveform_checker.
module multi_waveform_phase_oscillator_top_test;
  import mwpo_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_COUNT   = 6;
  localparam int TICKS_PER_PHASE = 275;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [FREQ_W-1:0]     cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int                    mismatch_count;
  int                    results_pending;
  int                    cycle_count = 0;
  int                    tx_idle_pct = 0;
  int                    rx_stall_pct = 0;
  logic [OFFSET_W-1:0]   last_sent_offset = '0;

  multi_waveform_phase_oscillator_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mwpo_waveform_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_waveform_phase_oscillator_top_test failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_tick(input logic [STEP_W-1:0] step, input logic [OFFSET_W-1:0] offset,
                           input logic [DUTY_W-1:0] duty, input logic restart);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({duty, offset, step});
    in_tuser  <= restart;
    last_sent_offset = offset;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_tick();
    logic [STEP_W-1:0]   step;
    logic [OFFSET_W-1:0] offset;
    logic [DUTY_W-1:0]   duty;
    case ($urandom_range(0, 3))
      0:       step = $urandom_range(0, 255);
      1:       step = $urandom_range(0, 32'h000F_FFFF);
      default: step = $urandom;
    endcase
    // mostly a slowly moving offset, sometimes a jump anywhere
    if ($urandom_range(0, 9) < 7)
      offset = last_sent_offset + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    else
      offset = $urandom;
    case ($urandom_range(0, 19))
      0:       duty = '0;
      1:       duty = 17'd65536;
      2, 3:    duty = DUTY_W'($urandom);
      default: duty = DUTY_W'($urandom_range(0, 65536));
    endcase
    send_tick(step, offset, duty, $urandom_range(0, 31) == 0);
  endtask

  // Drop valid and hold until every outstanding result has been delivered
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic write_frequency(input logic [FREQ_W-1:0] freq);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= freq;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [FREQ_W-1:0] freq;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    out_tready  = 1'b1;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset frequency is zero, so the phase follows the offset alone
    send_tick(32'h0000_0000, 32'h0000_0000, 17'd0,     1'b1);
    send_tick(32'hFFFF_FFFF, 32'h4000_0000, 17'd65536, 1'b0);
    send_tick(32'h0000_0000, 32'h8000_0000, 17'd32768, 1'b0);
    send_tick(32'h0000_0000, 32'hC000_0000, 17'h1FFFF, 1'b0);
    send_tick(32'h0000_0000, 32'hFFFF_FFFF, 17'd65537, 1'b0);
    send_tick(32'h0000_0000, 32'h3FFF_FFFF, 17'd1,     1'b0);
    send_tick(32'h0000_0000, 32'h7FFF_FFFF, 17'd32767, 1'b0);
    send_tick(32'h0000_0000, 32'hBFFF_FFFF, 17'd49152, 1'b0);
    send_tick(32'h0000_0000, 32'h0000_0001, 17'd0,     1'b0);
    send_tick(32'h0000_0000, 32'h8000_0001, 17'd65535, 1'b0);
    // restart with a nonzero offset: that offset becomes the new reference
    send_tick(32'hFFFF_FFFF, 32'h1234_5678, 17'd65536, 1'b1);
    send_tick(32'h0000_0000, 32'h1274_5678, 17'd16384, 1'b0);
    send_tick(32'h0000_0000, 32'h51F4_5678, 17'd16384, 1'b0);

    write_frequency(32'h0001_0000);
    send_tick(32'h4000_0000, 32'h51F4_5678, 17'd65536, 1'b0);
    send_tick(32'h8000_0000, 32'h51F4_5678, 17'd0,     1'b0);
    send_tick(32'hFFFF_FFFF, 32'h51F4_5678, 17'h1FFFF, 1'b0);
    send_tick(32'h0000_0000, 32'h0000_0000, 17'd32768, 1'b1);
    send_tick(32'h0000_0001, 32'h0000_0000, 17'd1,     1'b0);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       freq = 32'hFFFF_FFFF;
        1:       freq = 32'd440 << 16;
        2:       freq = 32'h0000_0000;
        3:       freq = 32'h0000_0001;
        default: freq = $urandom;
      endcase
      write_frequency(freq);
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 72; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 72; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (n == TICKS_PER_PHASE / 2) drain_results();
        send_random_tick();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("multi_waveform_phase_oscillator_top_test passed");
    else
      $display("multi_waveform_phase_oscillator_top_test failed");
    $finish;
  end

endmodule
